// ===== rtl/core/kst_pkg.sv =====
`default_nettype none
package kst_pkg;
  localparam int DEPTH = 64;
  localparam int PAYLOAD_W = 32;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    MODE_FIND  = 3'd0,
    MODE_BLANK = 3'd1,
    MODE_INS   = 3'd2,
    MODE_DEL   = 3'd3,
    MODE_CLR   = 3'd4,
    MODE_COUNT = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_I32 = 3'd0,
    KIND_I16 = 3'd1,
    KIND_F32 = 3'd2,
    KIND_F64 = 3'd3,
    KIND_STR = 3'd4
  } kind_t;

  // request sequencer states
  typedef enum logic [1:0] {S_IDLE, S_CMP, S_ACT, S_OUT} ctrl_state_t;

  // per-cycle command broadcast from the controller to every cell
  typedef struct packed {
    logic       insert; // write key/payload into the chosen slot
    logic       clear;  // blank the chosen slot
    logic       shift;  // chosen slot and all later take their upper neighbour
    logic [IDX_W-1:0] sel;
  } cell_cmd_t;

  // blank rule per key kind
  function automatic logic is_blank(input logic [2:0] kind, input logic [63:0] k);
    case (kind)
      KIND_I32: is_blank = (k[31:0] == 32'd0);
      KIND_I16: is_blank = (k[15:0] == 16'd0);
      KIND_F32: is_blank = (k[30:0] == 31'd0);
      KIND_F64: is_blank = (k[62:0] == 63'd0);
      KIND_STR: is_blank = (k[7:0] == 8'd0);
      default:  is_blank = (k == 64'd0);
    endcase
  endfunction

  // equality rule per key kind
  function automatic logic keys_match(input logic [2:0] kind, input logic [63:0] a,
                                      input logic [63:0] b);
    logic nan_a;
    logic nan_b;
    logic done;
    logic res;
    nan_a = 1'b0;
    nan_b = 1'b0;
    done = 1'b0;
    res = 1'b1;
    case (kind)
      KIND_I32: keys_match = (a[31:0] == b[31:0]);
      KIND_I16: keys_match = (a[15:0] == b[15:0]);
      KIND_F32: begin
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        keys_match = !nan_a && !nan_b &&
                     (((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) || (a[31:0] == b[31:0]));
      end
      KIND_F64: begin
        nan_a = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        nan_b = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        keys_match = !nan_a && !nan_b &&
                     (((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) || (a == b));
      end
      KIND_STR: begin
        for (int n = 0; n < 8; n++) begin
          if (!done) begin
            if (a[8*n +: 8] != b[8*n +: 8]) begin
              res = 1'b0;
              done = 1'b1;
            end else if (a[8*n +: 8] == 8'd0) begin
              done = 1'b1;
            end
          end
        end
        keys_match = res;
      end
      default: keys_match = (a == b);
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/kst_cell.sv =====
`default_nettype none
// One table slot: holds key and payload, tests them against the broadcast
// request, and takes its upper neighbour's contents on a shift.
module kst_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [kst_pkg::IDX_W-1:0]    slot_id,
  input  wire logic [2:0]                   kind,
  input  wire logic [63:0]                  req_key,
  input  wire logic [kst_pkg::PAYLOAD_W-1:0] req_payload,
  input  wire kst_pkg::cell_cmd_t           cmd,
  input  wire logic [63:0]                  up_key,
  input  wire logic [kst_pkg::PAYLOAD_W-1:0] up_payload,
  output logic [63:0]                       key,
  output logic [kst_pkg::PAYLOAD_W-1:0]     payload,
  output logic                              hit,
  output logic                              blank
);
  logic chosen;
  logic at_or_above;

  assign chosen      = (cmd.sel == slot_id);
  assign at_or_above = (slot_id >= cmd.sel);

  // registered compare results, read by the controller
  always_ff @(posedge clk) begin
    hit   <= kst_pkg::keys_match(kind, key, req_key);
    blank <= kst_pkg::is_blank(kind, key);
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      key     <= '0;
      payload <= '0;
    end else if (cmd.shift && at_or_above) begin
      key     <= up_key;
      payload <= up_payload;
    end else if (cmd.insert && chosen) begin
      key     <= req_key;
      payload <= req_payload;
    end else if (cmd.clear && chosen) begin
      key     <= '0;
      payload <= '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/kst_ctrl.sv =====
`default_nettype none
// Request sequencer: latches a request, waits for the cells' registered
// flags, priority-picks the first slot and issues the update.
module kst_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   mode_in,
  input  wire logic [63:0]                  key_in,
  input  wire logic [kst_pkg::PAYLOAD_W-1:0] payload_in,
  output logic [63:0]                       req_key,
  output logic [kst_pkg::PAYLOAD_W-1:0]     req_payload,
  input  wire logic [kst_pkg::DEPTH-1:0]    hits,
  input  wire logic [kst_pkg::DEPTH-1:0]    blanks,
  output kst_pkg::cell_cmd_t                cmd,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              ok,
  output logic [6:0]                        index
);
  kst_pkg::ctrl_state_t state, state_next;
  logic [2:0] mode;
  logic [kst_pkg::DEPTH-1:0] flags;
  logic found;
  logic [kst_pkg::IDX_W-1:0] first;
  logic use_blank;

  assign in_stall  = (state != kst_pkg::S_IDLE);
  assign out_valid = (state == kst_pkg::S_OUT);
  assign use_blank = (mode == kst_pkg::MODE_BLANK) || (mode == kst_pkg::MODE_INS) ||
                     (mode == kst_pkg::MODE_COUNT);
  assign flags = use_blank ? blanks : hits;

  // priority pick of the lowest flagged slot
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = kst_pkg::DEPTH - 1; i >= 0; i--) begin
      if (flags[i]) begin
        found = 1'b1;
        first = i[kst_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kst_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.sel = first;
    case (state)
      kst_pkg::S_IDLE: if (in_valid) state_next = kst_pkg::S_CMP;
      kst_pkg::S_CMP:  state_next = kst_pkg::S_ACT;
      kst_pkg::S_ACT: begin
        state_next = kst_pkg::S_OUT;
        if (found) begin
          cmd.insert = (mode == kst_pkg::MODE_INS);
          cmd.shift  = (mode == kst_pkg::MODE_DEL);
          cmd.clear  = (mode == kst_pkg::MODE_CLR);
        end
      end
      kst_pkg::S_OUT: if (!out_stall) state_next = kst_pkg::S_IDLE;
      default: state_next = kst_pkg::S_IDLE;
    endcase
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (state == kst_pkg::S_IDLE && in_valid) begin
      mode        <= mode_in;
      req_key     <= key_in;
      req_payload <= payload_in;
    end
    if (state == kst_pkg::S_ACT) begin
      case (mode)
        kst_pkg::MODE_FIND, kst_pkg::MODE_BLANK, kst_pkg::MODE_INS,
        kst_pkg::MODE_DEL, kst_pkg::MODE_CLR: begin
          ok    <= found;
          index <= found ? 7'(first) : 7'd0;
        end
        kst_pkg::MODE_COUNT: begin
          ok    <= 1'b1;
          index <= found ? 7'(first) : 7'(kst_pkg::DEPTH);
        end
        default: begin
          ok    <= 1'b0;
          index <= 7'd0;
        end
      endcase
    end
  end

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.insert, cmd.shift, cmd.clear}) <= 1) else $error("multiple commands");
  a_cmd_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert || cmd.shift || cmd.clear) |-> state == kst_pkg::S_ACT)
    else $error("stray command");
  a_out_next: assert property (@(posedge clk) disable iff (rst)
    state == kst_pkg::S_ACT |=> out_valid) else $error("result missing");
endmodule
`default_nettype wire

// ===== rtl/core/keyed_slot_table_unit.sv =====
`default_nettype none
// Keyed slot table of kst_pkg::DEPTH slots held in a chain of cells. Each
// request passes from acceptance to result through capture, a compare of
// every cell's slot against the key, a pick of the first slot with the update
// (delete shifts all later slots down in the same update), then the result
// register. One request is in flight at a time; key_kind is written through
// its own valid/ready port while no request is pending.
module keyed_slot_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  key_kind,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [63:0] key,
  input  wire logic [31:0] payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [6:0]       index
);
  localparam int D = kst_pkg::DEPTH;
  logic [2:0] kind;
  logic [63:0] req_key;
  logic [kst_pkg::PAYLOAD_W-1:0] req_payload;
  kst_pkg::cell_cmd_t cmd;
  logic [D-1:0] hits, blanks;
  logic [63:0] keys [D+1];
  logic [kst_pkg::PAYLOAD_W-1:0] pays [D+1];

  // key kind only changes while the sequencer is idle
  assign cfg_ready = !in_stall;
  always_ff @(posedge clk) begin
    if (rst) kind <= kst_pkg::KIND_I32;
    else if (cfg_valid && cfg_ready) kind <= key_kind;
  end

  // beyond the last slot a blank entry shifts in
  assign keys[D] = '0;
  assign pays[D] = '0;

  for (genvar g = 0; g < D; g++) begin : g_cell
    kst_cell u_cell (
      .clk(clk), .rst(rst),
      .slot_id(g[kst_pkg::IDX_W-1:0]),
      .kind(kind), .req_key(req_key), .req_payload(req_payload), .cmd(cmd),
      .up_key(keys[g+1]), .up_payload(pays[g+1]),
      .key(keys[g]), .payload(pays[g]),
      .hit(hits[g]), .blank(blanks[g])
    );
  end

  kst_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode_in(mode), .key_in(key), .payload_in(payload[kst_pkg::PAYLOAD_W-1:0]),
    .req_key(req_key), .req_payload(req_payload),
    .hits(hits), .blanks(blanks), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok), .index(index)
  );

  a_ok_idx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> index == 7'd0) else $error("failed result with index");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(index)) else $error("result lost");
  a_last: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.shift) |-> keys[D-1] == 64'd0) else $error("last slot not blanked");
endmodule
`default_nettype wire

// ===== test/tb_keyed_slot_table_unit.sv =====
`timescale 1ns / 1ps

module tb_keyed_slot_table_unit;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       ok;
    logic [6:0] index;
  } table_result_t;

  // Table model: slot contents, key kind and the results still owed
  class slot_table_scoreboard;
    logic [63:0] slot_key [kst_pkg::DEPTH];
    logic [31:0] slot_pay [kst_pkg::DEPTH];
    logic [2:0] kind;
    table_result_t owed[$];
    int errors;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_pay[i] = '0;
      end
      kind = kst_pkg::KIND_I32;
      errors = 0;
    endfunction

    function bit free_key(logic [63:0] k);
      case (kind)
        kst_pkg::KIND_I32: return k[31:0] == 0;
        kst_pkg::KIND_I16: return k[15:0] == 0;
        kst_pkg::KIND_F32: return k[30:0] == 0;
        kst_pkg::KIND_F64: return k[62:0] == 0;
        kst_pkg::KIND_STR: return k[7:0] == 0;
        default:  return k == 0;
      endcase
    endfunction

    function bit same_key(logic [63:0] a, logic [63:0] b);
      bit a_nan;
      bit b_nan;
      case (kind)
        kst_pkg::KIND_I32: return a[31:0] == b[31:0];
        kst_pkg::KIND_I16: return a[15:0] == b[15:0];
        kst_pkg::KIND_F32: begin
          a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
          b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
          if (a_nan || b_nan) return 0;
          return (a[30:0] == 0 && b[30:0] == 0) || a[31:0] == b[31:0];
        end
        kst_pkg::KIND_F64: begin
          a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
          b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
          if (a_nan || b_nan) return 0;
          return (a[62:0] == 0 && b[62:0] == 0) || a == b;
        end
        kst_pkg::KIND_STR: begin
          // bytes compared up to and including the terminating NUL
          for (int n = 0; n < 8; n++) begin
            if (a[8*n +: 8] != b[8*n +: 8]) return 0;
            if (a[8*n +: 8] == 0) return 1;
          end
          return 1;
        end
        default: return a == b;
      endcase
    endfunction

    function int first_hit(logic [63:0] k);
      for (int i = 0; i < kst_pkg::DEPTH; i++)
        if (same_key(slot_key[i], k)) return i;
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < kst_pkg::DEPTH; i++)
        if (free_key(slot_key[i])) return i;
      return -1;
    endfunction

    // apply an accepted request and queue its result
    function void note_request(logic [2:0] m, logic [63:0] k, logic [31:0] p);
      int s;
      table_result_t r;
      s = -1;
      case (m)
        kst_pkg::MODE_FIND:  s = first_hit(k);
        kst_pkg::MODE_BLANK: s = first_free();
        kst_pkg::MODE_INS: begin
          s = first_free();
          if (s >= 0) begin
            slot_key[s] = k;
            slot_pay[s] = p;
          end
        end
        kst_pkg::MODE_DEL: begin
          s = first_hit(k);
          if (s >= 0) begin
            for (int j = s; j < kst_pkg::DEPTH - 1; j++) begin
              slot_key[j] = slot_key[j+1];
              slot_pay[j] = slot_pay[j+1];
            end
            slot_key[kst_pkg::DEPTH-1] = '0;
            slot_pay[kst_pkg::DEPTH-1] = '0;
          end
        end
        kst_pkg::MODE_CLR: begin
          s = first_hit(k);
          if (s >= 0) begin
            slot_key[s] = '0;
            slot_pay[s] = '0;
          end
        end
        kst_pkg::MODE_COUNT: begin
          s = first_free();
          if (s < 0) s = kst_pkg::DEPTH;
        end
        default: s = -1;
      endcase
      r.ok = (s >= 0);
      r.index = (s >= 0) ? 7'(s) : 7'd0;
      owed.push_back(r);
    endfunction

    function void check_result(logic ok_seen, logic [6:0] idx_seen);
      table_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result ok=%0b index=%0d", $time, ok_seen, idx_seen);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (ok_seen !== e.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, e.ok, ok_seen);
        errors++;
      end
      if (idx_seen !== e.index) begin
        $display("%0t: index expected %0d actual %0d", $time, e.index, idx_seen);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  key_kind;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  mode;
  logic [63:0] key;
  logic [31:0] payload;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [6:0]  index;

  slot_table_scoreboard sb = new();
  int in_idle_pct;
  int out_stall_pct;
  int hold_left;
  int idle_cycles;

  keyed_slot_table_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .key_kind(key_kind),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .payload(payload),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .index(index)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver back-pressure, with an optional long hold
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < out_stall_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(ok, index);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_keyed_slot_table_unit failed");
        $finish;
      end
    end
  end

  // issue one request; entered and left on a falling edge
  task automatic send_request(logic [2:0] m, logic [63:0] k, logic [31:0] p);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    mode = m;
    key = k;
    payload = p;
    do @(posedge clk); while (in_stall);
    sb.note_request(m, k, p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_kind(logic [2:0] k);
    drain();
    cfg_valid = 1'b1;
    key_kind = k;
    do @(posedge clk); while (!cfg_ready);
    sb.kind = k;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // key for the current kind: often one already stored, else edge cases or random keys
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int len;
    k = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        k = sb.slot_key[$urandom_range(kst_pkg::DEPTH - 1)];
        if ($urandom_range(1)) begin
          // disturb bits that play no part in the comparison
          if (sb.kind == kst_pkg::KIND_I32) k[63:32] = $urandom;
          if (sb.kind == kst_pkg::KIND_I16) k[63:16] = {$urandom, 16'($urandom)};
        end
      end
      4: begin
        case (sb.kind)
          kst_pkg::KIND_I32: k[31:0] = '0;
          kst_pkg::KIND_I16: k[15:0] = '0;
          kst_pkg::KIND_F32: k[30:0] = '0;
          kst_pkg::KIND_F64: k[62:0] = '0;
          default:  k[7:0] = '0;
        endcase
      end
      5: begin
        case (sb.kind)
          kst_pkg::KIND_F32: k[30:23] = 8'hFF;
          kst_pkg::KIND_F64: k[62:52] = 11'h7FF;
          kst_pkg::KIND_I16: k[15:0] = 16'hFFFF;
          default:  k = {8{8'hFF}};
        endcase
      end
      default: begin
        if (sb.kind == kst_pkg::KIND_STR) begin
          len = $urandom_range(1, 8);
          for (int n = 0; n < 8; n++)
            if (n < len) k[8*n +: 8] = 8'($urandom_range(1, 255));
            else if (n == len) k[8*n +: 8] = '0;
        end else if (sb.kind == kst_pkg::KIND_I16 && $urandom_range(1)) begin
          k[15:0] = 16'($urandom_range(1, 16));
        end
      end
    endcase
    return k;
  endfunction

  task automatic random_requests(int count, int ins_pct);
    logic [2:0] m;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) m = kst_pkg::MODE_INS;
      else if (r < ins_pct + (100 - ins_pct) * 3 / 10) m = kst_pkg::MODE_FIND;
      else if (r < ins_pct + (100 - ins_pct) * 5 / 10) m = kst_pkg::MODE_DEL;
      else if (r < ins_pct + (100 - ins_pct) * 7 / 10) m = kst_pkg::MODE_CLR;
      else if (r < ins_pct + (100 - ins_pct) * 85 / 100) m = kst_pkg::MODE_BLANK;
      else m = kst_pkg::MODE_COUNT;
      send_request(m, pick_key(), $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    key_kind = kst_pkg::KIND_I32;
    in_valid = 1'b0;
    mode = kst_pkg::MODE_FIND;
    key = '0;
    payload = '0;
    out_stall = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, field extremes, every operation
    send_request(kst_pkg::MODE_COUNT, '0, '0);
    send_request(kst_pkg::MODE_BLANK, '0, '0);
    send_request(kst_pkg::MODE_FIND, '0, '0);
    send_request(kst_pkg::MODE_INS, '1, '1);
    send_request(kst_pkg::MODE_INS, 64'd1, '0);
    send_request(kst_pkg::MODE_FIND, 64'h0000_0000_FFFF_FFFF, '0);
    send_request(kst_pkg::MODE_CLR, 64'd1, '0);
    send_request(kst_pkg::MODE_DEL, '1, '0);
    send_request(kst_pkg::MODE_FIND, 64'd77, '0);
    send_request(kst_pkg::MODE_INS, 64'hABCD_0000_0000_0000, 32'h5A5A_A5A5);
    send_request(kst_pkg::MODE_COUNT, '0, '0);
    write_kind(kst_pkg::KIND_F64);
    send_request(kst_pkg::MODE_INS, 64'h8000_0000_0000_0000, 32'd3);
    send_request(kst_pkg::MODE_INS, 64'h7FF8_0000_0000_0001, 32'd4);
    send_request(kst_pkg::MODE_FIND, 64'h7FF8_0000_0000_0001, '0);
    send_request(kst_pkg::MODE_INS, 64'h3FF0_0000_0000_0000, 32'd5);
    send_request(kst_pkg::MODE_FIND, 64'h3FF0_0000_0000_0000, '0);
    send_request(kst_pkg::MODE_FIND, 64'h0, '0);
    write_kind(kst_pkg::KIND_STR);
    send_request(kst_pkg::MODE_INS, 64'h7A79_7800_6261, 32'd6);
    send_request(kst_pkg::MODE_FIND, 64'h1111_1100_6261, '0);
    send_request(kst_pkg::MODE_INS, 64'h4847_4645_4443_4241, 32'd7);
    send_request(kst_pkg::MODE_FIND, 64'h4847_4645_4443_4241, '0);
    send_request(kst_pkg::MODE_DEL, 64'h0000_0000_6261, '0);

    // random phases across key kinds and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_kind((ph == 0) ? kst_pkg::KIND_I16 : 3'(ph % 5));
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 53; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 53; end
        default: begin in_idle_pct = 35; out_stall_pct = 35; end
      endcase
      if (ph == 2) begin
        in_idle_pct = 0;
        hold_left = HOLD_CYCLES;
      end
      random_requests(60, (ph % 2) ? 80 : 40);
      if (ph == 5) drain();
      random_requests(65, 30);
    end
    write_kind(kst_pkg::KIND_I32);
    random_requests(20, 40);

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb_keyed_slot_table_unit passed");
    end else begin
      $display("tb_keyed_slot_table_unit failed");
    end
    $finish;
  end
endmodule
